[design/hrsp_pkg.sv]
// Shared types, codes and constant tables for the HTTP response stream parser.
package hrsp_pkg;

	typedef enum logic [1:0] {
		PH_STATUS  = 2'd0,
		PH_HEADERS = 2'd1,
		PH_BODY    = 2'd2,
		PH_DONE    = 2'd3
	} hrsp_phase_t;

	typedef enum logic [1:0] {
		LP_FIRST  = 2'd0,
		LP_SECOND = 2'd1,
		LP_REST   = 2'd2
	} hrsp_part_t;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int unsigned TAG_LEN = 5;
	localparam int unsigned KEY_LEN = 14;
	localparam logic [9:0]  CODE_MAX = 10'd999;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       closed;
	} hrsp_rx_t;

	typedef struct packed {
		logic        body_valid;
		logic [7:0]  body_byte;
		logic        status_valid;
		logic [9:0]  status_code;
		logic        length_known;
		logic [31:0] content_length;
		logic        done_res;
		logic        failed;
		logic [1:0]  phase;
	} hrsp_res_t;

	// "HTTP/"
	function automatic logic [7:0] tag_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = 8'h48;
			3'd1: ch = 8'h54;
			3'd2: ch = 8'h54;
			3'd3: ch = 8'h50;
			3'd4: ch = 8'h2F;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// "Content-Length"
	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:  ch = 8'h43;
			4'd1:  ch = 8'h6F;
			4'd2:  ch = 8'h6E;
			4'd3:  ch = 8'h74;
			4'd4:  ch = 8'h65;
			4'd5:  ch = 8'h6E;
			4'd6:  ch = 8'h74;
			4'd7:  ch = 8'h2D;
			4'd8:  ch = 8'h4C;
			4'd9:  ch = 8'h65;
			4'd10: ch = 8'h6E;
			4'd11: ch = 8'h67;
			4'd12: ch = 8'h74;
			4'd13: ch = 8'h68;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

[design/hrsp_stream_if.sv]
// Valid/ready stream channel carrying one word of a given payload type.
interface hrsp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[design/http_response_stream_parser.sv]
// HTTP response parser: status line, Content-Length header and body pass-through.
//
//  channel | dir | payload              | word
//  --------+-----+----------------------+-------------------------------------------
//  rx      | in  | hrsp_pkg::hrsp_rx_t  | one received byte, or a connection close
//  res     | out | hrsp_pkg::hrsp_res_t | one result word per accepted rx word
//
// One rx word is taken per clock while rx.ready is high. The whole byte step (status, header or body
// handling) is worked out from the running parse state in the cycle of acceptance;
// its result is captured in the result register at the clock edge that accepts it.
// rx.ready is high whenever the result register is empty or being drained, so a
// waiting result does not stall the input unless res.ready is low.
// arst_n clears the parse state to the start of the status line, length unknown.
module http_response_stream_parser #(
	parameter int unsigned LENGTH_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	hrsp_stream_if.sink   rx,
	hrsp_stream_if.source res
);
	import hrsp_pkg::*;

	localparam logic [LENGTH_BITS-1:0] LEN_MASK = '1;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX  = LEN_MASK - LENGTH_BITS'(1);

	// running parse state
	hrsp_phase_t            phase_q;
	hrsp_part_t             part_q;
	logic [4:0]             col_q;
	logic                   prefix_ok_q;
	logic                   key_match_q;
	logic                   digits_stopped_q;
	logic                   line_empty_q;
	logic [9:0]             code_q;
	logic [LENGTH_BITS-1:0] len_acc_q;
	logic [LENGTH_BITS-1:0] len_val_q;
	logic                   len_seen_q;
	logic [LENGTH_BITS-1:0] body_cnt_q;

	hrsp_phase_t            phase_d;
	hrsp_part_t             part_d;
	logic [4:0]             col_d;
	logic                   prefix_ok_d;
	logic                   key_match_d;
	logic                   digits_stopped_d;
	logic                   line_empty_d;
	logic [9:0]             code_d;
	logic [LENGTH_BITS-1:0] len_acc_d;
	logic [LENGTH_BITS-1:0] len_val_d;
	logic                   len_seen_d;
	logic [LENGTH_BITS-1:0] body_cnt_d;

	// result register
	logic      res_valid_s1;
	hrsp_res_t res_word_s1;
	hrsp_res_t res_word_d;

	logic accept;
	assign rx.ready  = !res_valid_s1 || res.ready;
	assign accept    = rx.valid && rx.ready;
	assign res.valid = res_valid_s1;
	assign res.payload = res_word_s1;

	// input decode
	logic [7:0] ch;
	logic       is_digit;
	logic [3:0] digit;
	logic [13:0] code_ext;
	logic [LENGTH_BITS+3:0] len_ext;
	logic [9:0] code_next;
	logic [LENGTH_BITS-1:0] len_next;
	logic [LENGTH_BITS-1:0] body_inc;
	logic       col_lt_tag;
	logic       col_is_key;

	assign ch       = rx.payload.rx_byte;
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign digit    = ch[3:0];

	// decimal accumulate with saturation: code at 999, length at 2^LENGTH_BITS - 2
	assign code_ext  = {4'b0, code_q} * 14'd10 + {10'b0, digit};
	assign code_next = (code_ext > {4'b0, CODE_MAX}) ? CODE_MAX : code_ext[9:0];
	assign len_ext   = {4'b0, len_acc_q} * (LENGTH_BITS+4)'(10)
	                   + {{LENGTH_BITS{1'b0}}, digit};
	assign len_next  = (len_ext > {4'b0, LEN_MAX}) ? LEN_MAX : len_ext[LENGTH_BITS-1:0];
	assign body_inc  = (body_cnt_q != LEN_MASK) ? body_cnt_q + LENGTH_BITS'(1) : body_cnt_q;
	assign col_lt_tag = col_q < 5'(TAG_LEN);
	assign col_is_key = col_q == 5'(KEY_LEN);

	always_comb begin
		logic bv, sv, done, fl;
		logic line_end;

		phase_d          = phase_q;
		part_d           = part_q;
		col_d            = col_q;
		prefix_ok_d      = prefix_ok_q;
		key_match_d      = key_match_q;
		digits_stopped_d = digits_stopped_q;
		line_empty_d     = line_empty_q;
		code_d           = code_q;
		len_acc_d        = len_acc_q;
		len_val_d        = len_val_q;
		len_seen_d       = len_seen_q;
		body_cnt_d       = body_cnt_q;
		bv       = 1'b0;
		sv       = 1'b0;
		done     = 1'b0;
		fl       = 1'b0;
		line_end = 1'b0;

		if (phase_q == PH_DONE) begin
			// finished: everything ignored
		end else if (rx.payload.closed) begin
			if (phase_q == PH_BODY && !len_seen_q) begin
				done = 1'b1;
			end else begin
				code_d = '0;
				fl     = 1'b1;
			end
			phase_d = PH_DONE;
		end else if (phase_q == PH_BODY) begin
			bv         = 1'b1;
			body_cnt_d = body_inc;
			if (body_inc >= len_val_q) begin
				phase_d = PH_DONE;
				done    = 1'b1;
			end
		end else if (ch != CH_CR) begin
			if (phase_q == PH_STATUS) begin
				if (ch == CH_LF) begin
					line_end = 1'b1;
					// short first token, empty line included, is a bad status line
					if (!prefix_ok_q || (part_q == LP_FIRST && col_lt_tag)) begin
						code_d  = '0;
						phase_d = PH_DONE;
						fl      = 1'b1;
					end else begin
						phase_d = PH_HEADERS;
						sv      = 1'b1;
					end
				end else begin
					case (part_q)
						LP_FIRST: begin
							if (ch == CH_SPACE) begin
								if (col_lt_tag) prefix_ok_d = 1'b0;
								part_d = LP_SECOND;
							end else begin
								if (col_lt_tag && ch != tag_char(col_q[2:0]))
									prefix_ok_d = 1'b0;
								if (col_q != 5'd31) col_d = col_q + 5'd1;
							end
						end
						LP_SECOND: begin
							if (ch == CH_SPACE) part_d = LP_REST;
							else if (!digits_stopped_q && is_digit) code_d = code_next;
							else digits_stopped_d = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end else begin
				if (ch == CH_LF) begin
					line_end = 1'b1;
					if (line_empty_q) begin
						phase_d    = PH_BODY;
						body_cnt_d = '0;
						if (len_val_q == '0) begin
							phase_d = PH_DONE;
							done    = 1'b1;
						end
					end else if (part_q == LP_FIRST) begin
						// bare key with no colon
						if (key_match_q && col_is_key) begin
							len_val_d  = '0;
							len_seen_d = 1'b1;
						end
					end else if (key_match_q) begin
						len_val_d  = len_acc_q;
						len_seen_d = 1'b1;
					end
				end else begin
					line_empty_d = 1'b0;
					case (part_q)
						LP_FIRST: begin
							if (ch == CH_COLON) begin
								key_match_d = key_match_q && col_is_key;
								part_d      = LP_SECOND;
							end else begin
								if (col_q >= 5'(KEY_LEN) || ch != key_char(col_q[3:0]))
									key_match_d = 1'b0;
								if (col_q != 5'd31) col_d = col_q + 5'd1;
							end
						end
						default: begin
							// spaces after the colon are skipped, then the value
							if (!(part_q == LP_SECOND && ch == CH_SPACE)) begin
								part_d = LP_REST;
								if (!digits_stopped_q && is_digit) len_acc_d = len_next;
								else digits_stopped_d = 1'b1;
							end
						end
					endcase
				end
			end
		end

		if (line_end) begin
			col_d            = '0;
			part_d           = LP_FIRST;
			prefix_ok_d      = 1'b1;
			key_match_d      = 1'b1;
			digits_stopped_d = 1'b0;
			line_empty_d     = 1'b1;
			len_acc_d        = '0;
		end

		res_word_d.body_valid     = bv;
		res_word_d.body_byte      = bv ? ch : 8'h00;
		res_word_d.status_valid   = sv;
		res_word_d.status_code    = (phase_d == PH_STATUS) ? 10'd0 : code_d;
		res_word_d.length_known   = len_seen_d;
		res_word_d.content_length = len_seen_d ? 32'(len_val_d) : 32'd0;
		res_word_d.done_res       = done;
		res_word_d.failed         = fl;
		res_word_d.phase          = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_STATUS;
			part_q           <= LP_FIRST;
			col_q            <= '0;
			prefix_ok_q      <= 1'b1;
			key_match_q      <= 1'b1;
			digits_stopped_q <= 1'b0;
			line_empty_q     <= 1'b1;
			code_q           <= '0;
			len_acc_q        <= '0;
			len_val_q        <= LEN_MASK;
			len_seen_q       <= 1'b0;
			body_cnt_q       <= '0;
		end else if (accept) begin
			phase_q          <= phase_d;
			part_q           <= part_d;
			col_q            <= col_d;
			prefix_ok_q      <= prefix_ok_d;
			key_match_q      <= key_match_d;
			digits_stopped_q <= digits_stopped_d;
			line_empty_q     <= line_empty_d;
			code_q           <= code_d;
			len_acc_q        <= len_acc_d;
			len_val_q        <= len_val_d;
			len_seen_q       <= len_seen_d;
			body_cnt_q       <= body_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else if (accept) begin
			res_valid_s1 <= 1'b1;
		end else if (res.ready) begin
			res_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_word_s1 <= res_word_d;
		end
	end

endmodule
